// ===== rtl/sobel_edge_rgb_macros.svh =====
// Assertion macros for the Sobel edge block.
// Used by the controller and the top level; no other dependencies.
`ifndef SOBEL_EDGE_RGB_MACROS_SVH
`define SOBEL_EDGE_RGB_MACROS_SVH
`ifndef SYNTH
`define SE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m: lbl");
`define SE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: lbl");
`else
`define SE_ASSERT(lbl, clk, rstn, prop)
`define SE_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/sedge_pkg.sv =====
// Package for the Sobel edge block: constants, command and status types.
// No dependencies.
`default_nettype none
package sedge_pkg;
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 4096;
  localparam int unsigned PixW   = 24;
  localparam int unsigned FwW    = 11;
  localparam int unsigned FhW    = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;
  localparam logic [7:0] MagMax = 8'd255;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture input beat, start line-store read
    logic       shift;     // shift window with read data
    logic       calc;      // register sums of squares, clear root search
    logic       step;      // one bit of the root search
    logic [2:0] rbit;      // bit under test in the root search
    logic       emit;      // load the result into the output register
    logic       clr_win;   // clear window (frame end)
    logic       drain;     // input beat is a drain
    logic       first_col; // output pixel is column 0
    logic       last_col;
    logic       first_row;
    logic       last_row;
    logic       frame_end;
  } sedge_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // output register holds a beat not yet taken
  } sedge_sts_t;
endpackage
`default_nettype wire

// ===== rtl/sedge_if.sv =====
// Valid/ready stream interface used by every channel of the Sobel block.
// Width of the payload is a parameter.
`default_nettype none
interface sedge_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sedge_ctrl.sv =====
// Controller of the Sobel block: counters, frame position, handshake sequencing.
// Depends on sedge_pkg and the macro header.
`default_nettype none
`include "sobel_edge_rgb_macros.svh"
module sedge_ctrl #(
  parameter int unsigned MaxWidth  = sedge_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = sedge_pkg::MaxHeightDef,
  parameter int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      in_mode_i,
  input  wire logic [sedge_pkg::FwW-1:0] frame_width_i,
  input  wire logic [sedge_pkg::FhW-1:0] frame_height_i,
  input  wire sedge_pkg::sedge_sts_t     sts_i,
  output sedge_pkg::sedge_cmd_t          cmd_o,
  output logic [ColW-1:0]                col_o
);
  import sedge_pkg::*;
  localparam int unsigned WW = $clog2(MaxWidth + 2) + 1;
  localparam int unsigned HW = $clog2(MaxHeight + 1) + 1;
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StShift = 2'd1;
  localparam logic [1:0] StRoot  = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [2:0]    bit_q, bit_d;
  logic [WW-1:0] pend_q, pend_d;
  logic [WW-1:0] ccol_q, ccol_d;
  logic [HW-1:0] crow_q, crow_d;
  logic          outph_q, outph_d;
  logic          drain_q, drain_d;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] c;
  logic          take, outph, lcol, lrow;

  always_comb begin
    if (frame_width_i == '0) w_eff = WW'(1);
    else if ({1'b0, frame_width_i} > (FwW+1)'(MaxWidth)) w_eff = WW'(MaxWidth);
    else w_eff = WW'(frame_width_i);
    if (frame_height_i == '0) h_eff = HW'(1);
    else if ({1'b0, frame_height_i} > (FhW+1)'(MaxHeight)) h_eff = HW'(MaxHeight);
    else h_eff = HW'(frame_height_i);
  end

  assign in_ready_o = (state_q == StIdle) && !sts_i.out_busy;
  assign take  = in_valid_i && in_ready_o;
  assign outph = pend_q >= w_eff + WW'(1);
  assign lcol  = ccol_q >= w_eff - WW'(1);
  assign lrow  = crow_q >= h_eff - HW'(1);

  always_comb begin
    if (!outph) c = (pend_q < w_eff) ? pend_q : '0;
    else c = (ccol_q + WW'(1) >= w_eff) ? '0 : ccol_q + WW'(1);
  end
  assign col_o = c[ColW-1:0];

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    pend_d  = pend_q;
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    outph_d = outph_q;
    drain_d = drain_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (take && !(in_mode_i && pend_q == '0)) begin
          cmd_o.load = 1'b1;
          drain_d = in_mode_i;
          outph_d = outph;
          if (!outph) pend_d = pend_q + WW'(1);
          state_d = StShift;
        end
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        cmd_o.drain = drain_q;
        state_d = StIdle;
        if (outph_q) begin
          cmd_o.calc      = 1'b1;
          cmd_o.first_col = ccol_q == '0;
          cmd_o.last_col  = lcol;
          cmd_o.first_row = crow_q == '0;
          cmd_o.last_row  = lrow;
          cmd_o.frame_end = lcol && lrow;
          bit_d   = 3'd7;
          state_d = StRoot;
          if (lcol && lrow) begin
            cmd_o.clr_win = 1'b1;
            ccol_d = '0; crow_d = '0; pend_d = '0;
          end else if (lcol) begin
            ccol_d = '0; crow_d = crow_q + HW'(1);
          end else ccol_d = ccol_q + WW'(1);
        end
      end
      // root search, most significant bit first
      StRoot: begin
        cmd_o.step = 1'b1;
        cmd_o.rbit = bit_q;
        if (bit_q == 3'd0) state_d = StOut;
        else bit_d = bit_q - 3'd1;
      end
      StOut: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bit_q <= '0;
      pend_q <= '0; ccol_q <= '0; crow_q <= '0;
      outph_q <= 1'b0; drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q <= bit_d;
      pend_q <= pend_d; ccol_q <= ccol_d; crow_q <= crow_d;
      outph_q <= outph_d; drain_q <= drain_d;
    end
  end

  `SE_ASSERT(a_load_then_shift, clk_i, rst_ni, cmd_o.load |=> cmd_o.shift)
  `SE_ASSERT(a_no_take_busy, clk_i, rst_ni, (state_q != StIdle) |-> !in_ready_o)
  `SE_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= WW'(MaxWidth + 1))
  `SE_ASSERT(a_end_clears, clk_i, rst_ni, cmd_o.frame_end |=> pend_q == '0)
  `SE_ASSERT(a_calc_to_emit, clk_i, rst_ni, cmd_o.calc |-> ##9 cmd_o.emit)
endmodule
`default_nettype wire

// ===== rtl/sedge_dp.sv =====
// Datapath of the Sobel block: line-store memory, 3x3 window, magnitude, output register.
// Depends on sedge_pkg.
`default_nettype none
module sedge_dp #(
  parameter int unsigned MaxWidth = sedge_pkg::MaxWidthDef,
  parameter int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sedge_pkg::sedge_cmd_t      cmd_i,
  input  wire logic [ColW-1:0]            col_i,
  input  wire logic [sedge_pkg::PixW-1:0] pix_i,
  output sedge_pkg::sedge_sts_t           sts_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [sedge_pkg::PixW:0]        out_data_o
);
  import sedge_pkg::*;
  // one memory, two rows packed per entry: top 47:24, mid 23:0
  logic [2*PixW-1:0] mem [MaxWidth];
  logic [2*PixW-1:0] rd_q;
  logic [ColW-1:0]   col_q;
  logic [PixW-1:0]   v_q;
  logic [PixW-1:0]   win_q [3][3]; // [row][col]
  logic [PixW-1:0]   cols [3][3];  // [col][row]
  logic [PixW-1:0]   top, mid, v;
  logic [20:0]       s_d [3];
  logic [20:0]       s_q [3];
  logic [7:0]        r_d [3];
  logic [7:0]        r_q [3];
  logic [7:0]        mag [3];
  logic              fe_q;
  logic              ov_q;
  logic [PixW:0]     od_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q  <= mem[col_i];
      col_q <= col_i;
      v_q   <= pix_i;
    end
    if (cmd_i.shift) mem[col_q] <= {rd_q[PixW-1:0], v};
  end

  assign top = rd_q[2*PixW-1:PixW];
  assign mid = rd_q[PixW-1:0];
  assign v   = cmd_i.drain ? '0 : v_q;

  // window after this beat's shift; last column output uses the window before it
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (cmd_i.last_col) begin
        cols[0][r] = win_q[r][1];
        cols[1][r] = win_q[r][2];
        cols[2][r] = '0;
      end else begin
        cols[0][r] = win_q[r][1];
        cols[1][r] = win_q[r][2];
        cols[2][r] = (r == 0) ? top : (r == 1) ? mid : v;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.first_col) cols[0][k] = '0;
      if (cmd_i.last_col)  cols[2][k] = '0;
      if (cmd_i.first_row) cols[k][0] = '0;
      if (cmd_i.last_row)  cols[k][2] = '0;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [11:0] gx, gy;
    logic signed [23:0] sqx, sqy;
    logic [7:0]         t;
    logic [15:0]        tt;
    logic [16:0]        rr;
    always_comb begin
      gx = 12'(cols[2][0][ch*8 +: 8]) + (12'(cols[2][1][ch*8 +: 8]) << 1)
         + 12'(cols[2][2][ch*8 +: 8]) - 12'(cols[0][0][ch*8 +: 8])
         - (12'(cols[0][1][ch*8 +: 8]) << 1) - 12'(cols[0][2][ch*8 +: 8]);
      gy = 12'(cols[0][2][ch*8 +: 8]) + (12'(cols[1][2][ch*8 +: 8]) << 1)
         + 12'(cols[2][2][ch*8 +: 8]) - 12'(cols[0][0][ch*8 +: 8])
         - (12'(cols[1][0][ch*8 +: 8]) << 1) - 12'(cols[2][0][ch*8 +: 8]);
      sqx = gx * gx;
      sqy = gy * gy;
      s_d[ch] = 21'(sqx) + 21'(sqy);
      // one bit of floor(sqrt(s)) per step
      t  = r_q[ch] | (8'd1 << cmd_i.rbit);
      tt = 16'(t) * 16'(t);
      r_d[ch] = (21'(tt) <= s_q[ch]) ? t : r_q[ch];
      // round half up against r*r + r, clamp above 255
      rr = 17'(16'(r_q[ch]) * 16'(r_q[ch])) + 17'(r_q[ch]);
      if (s_q[ch] > 21'd65280) mag[ch] = MagMax;
      else if (s_q[ch] > 21'(rr)) mag[ch] = r_q[ch] + 8'd1;
      else mag[ch] = r_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= s_d[k];
        r_q[k] <= '0;
      end
      fe_q <= cmd_i.frame_end;
    end else if (cmd_i.step) begin
      for (int k = 0; k < 3; k++) r_q[k] <= r_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
    end else if (cmd_i.clr_win) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top;
      win_q[1][2] <= mid;
      win_q[2][2] <= v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) od_q <= {mag[2], mag[1], mag[0], fe_q};
  end

  assign out_valid_o   = ov_q;
  assign out_data_o    = od_q;
  assign sts_o.out_busy = ov_q && !out_ready_i;
endmodule
`default_nettype wire

// ===== rtl/sobel_edge_rgb.sv =====
// Top level of the streaming 3x3 Sobel edge block on RGB pixels.
// Depends on sedge_pkg, sedge_if, sedge_ctrl, sedge_dp and the macro header.
//   channel | dir | payload
//   in_s    | in  | data[24] mode, [23:16] red, [15:8] green, [7:0] blue
//   cfg_s   | in  | data[13:0]: [13] index, [12:0] value
//   out_m   | out | data[24:17] red, [16:9] green, [8:1] blue, [0] frame_end
// A beat that yields a result goes through accept, window shift with the
// sums of squares, root search over eight bits (one bit per step), output load.
// A fill beat is accepted and shifted into the window only; an ignored drain is
// just accepted. The single-port line store and bit-serial root set these steps.
// Input stalls while the output register holds a beat not yet taken.
// Reset clears counters and window; the line store is not cleared.
`default_nettype none
`include "sobel_edge_rgb_macros.svh"
module sobel_edge_rgb #(
  parameter int unsigned MaxWidth  = sedge_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = sedge_pkg::MaxHeightDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sedge_if.sink    in_s,
  sedge_if.sink    cfg_s,
  sedge_if.source  out_m
);
  import sedge_pkg::*;
  localparam int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  logic [FwW-1:0] fw_q;
  logic [FhW-1:0] fh_q;
  sedge_cmd_t     cmd;
  sedge_sts_t     sts;
  logic [ColW-1:0] col;

  // cfg data: bit 13 index, bits 12:0 value
  assign cfg_s.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FwW'(1024);
      fh_q <= FhW'(768);
    end else if (cfg_s.valid) begin
      case (cfg_s.data[13])
        RegFrameWidth:  fw_q <= cfg_s.data[FwW-1:0];
        RegFrameHeight: fh_q <= cfg_s.data[FhW-1:0];
        default: ;
      endcase
    end
  end

  sedge_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_s.valid), .in_ready_o(in_s.ready), .in_mode_i(in_s.data[24]),
    .frame_width_i(fw_q), .frame_height_i(fh_q),
    .sts_i(sts), .cmd_o(cmd), .col_o(col)
  );

  sedge_dp #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .col_i(col), .pix_i(in_s.data[PixW-1:0]),
    .sts_o(sts), .out_valid_o(out_m.valid), .out_ready_i(out_m.ready),
    .out_data_o(out_m.data)
  );

  `SE_ASSERT(a_emit_free, clk_i, rst_ni, cmd.emit |-> !(out_m.valid && !out_m.ready))
  `SE_ASSERT(a_out_hold, clk_i, rst_ni, (out_m.valid && !out_m.ready) |=> out_m.valid)
  `SE_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |-> !out_m.valid)
endmodule
`default_nettype wire

// ===== bench/tb_sobel_edge_rgb.sv =====
// Self-checking bench for sobel_edge_rgb: directed rows, fixed and random frames,
// scored by a local predictor or typed results. Needs sedge_pkg, sedge_if, RTL.
module tb_sobel_edge_rgb;
  import sedge_pkg::*;

  localparam int unsigned LineLen   = MaxWidthDef;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandItems  = 560;

  typedef enum logic [1:0] {RowCfg, RowPix, RowDrn} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    logic [12:0] val;   // cfg value, or unused
    logic        idx;
    logic [23:0] pix;
    bit          typed;
    logic [24:0] res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  always #5 clk_i = ~clk_i;

  sedge_if #(25) in_if ();
  sedge_if #(14) cfg_if ();
  sedge_if #(25) out_if ();

  sobel_edge_rgb u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_if.sink),
    .cfg_s (cfg_if.sink),
    .out_m (out_if.source)
  );

  // predictor state
  logic [23:0]  lstore [2*LineLen];
  logic [23:0]  win [3][3];   // [row][col]
  int unsigned  col_n, row_n, pend_n;
  logic [10:0]  fw_q;
  logic [12:0]  fh_q;
  bit           frame_done;

  logic [24:0]  mag_q [$];
  int unsigned  errs;
  int unsigned  n_items;
  int unsigned  quiet_cnt;
  bit           quiet;
  bit           hold_req;

  function automatic int unsigned width_eff();
    if (fw_q == 0) return 1;
    if (fw_q > LineLen) return LineLen;
    return fw_q;
  endfunction

  function automatic int unsigned height_eff();
    if (fh_q == 0) return 1;
    if (fh_q > MaxHeightDef) return MaxHeightDef;
    return fh_q;
  endfunction

  function automatic logic [7:0] root_rnd(int unsigned s);
    int unsigned r;
    r = 0;
    if (s > 65280) return 8'd255;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s > r * r + r) r++;
    return r[7:0];
  endfunction

  // taps[k][r]: k column left..right, r row top..bottom
  function automatic logic [7:0] chan_mag(logic [23:0] taps [3][3], int sh);
    int p [3][3];
    int gx, gy;
    for (int k = 0; k < 3; k++)
      for (int r = 0; r < 3; r++) p[k][r] = (taps[k][r] >> sh) & 8'hff;
    gx = (p[2][0] + 2*p[2][1] + p[2][2]) - (p[0][0] + 2*p[0][1] + p[0][2]);
    gy = (p[0][2] + 2*p[1][2] + p[2][2]) - (p[0][0] + 2*p[1][0] + p[2][0]);
    return root_rnd(gx*gx + gy*gy);
  endfunction

  function automatic void clear_frame();
    col_n = 0; row_n = 0; pend_n = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) win[r][k] = '0;
  endfunction

  function automatic bit sobel_step(logic drain, logic [23:0] pix, output logic [24:0] res);
    int unsigned w, h, c;
    logic [23:0] v, top, mid;
    logic [23:0] taps [3][3];
    bit outp, lc, lr, fe;
    w = width_eff();
    h = height_eff();
    res = '0;
    if (drain && pend_n == 0) return 0;
    v = drain ? 24'd0 : pix;
    outp = pend_n >= w + 1;
    if (!outp) begin
      c = (pend_n < w) ? pend_n : 0;
      pend_n++;
    end else begin
      c = (col_n + 1 >= w) ? 0 : col_n + 1;
    end
    // on a row wrap the window still holds the previous row's right edge
    if (outp && c == 0) begin
      for (int r = 0; r < 3; r++) begin
        taps[0][r] = win[r][1];
        taps[1][r] = win[r][2];
        taps[2][r] = '0;
      end
    end
    top = lstore[LineLen + c];
    mid = lstore[c];
    lstore[LineLen + c] = mid;
    lstore[c] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top; win[1][2] = mid; win[2][2] = v;
    if (!outp) return 0;
    if (c != 0)
      for (int k = 0; k < 3; k++)
        for (int r = 0; r < 3; r++) taps[k][r] = win[r][k];
    lc = col_n >= w - 1;
    lr = row_n >= h - 1;
    fe = lc && lr;
    for (int k = 0; k < 3; k++) begin
      if (col_n == 0) taps[0][k] = '0;
      if (lc) taps[2][k] = '0;
      if (row_n == 0) taps[k][0] = '0;
      if (lr) taps[k][2] = '0;
    end
    res = {chan_mag(taps, 16), chan_mag(taps, 8), chan_mag(taps, 0), fe};
    if (fe) begin
      clear_frame();
      frame_done = 1'b1;
    end else if (lc) begin
      col_n = 0;
      row_n++;
    end else begin
      col_n++;
    end
    return 1;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // one beat on the pixel channel; prediction on acceptance
  task automatic send_beat(logic drain, logic [23:0] pix, bit typed, logic [24:0] tres);
    logic [24:0] res;
    in_if.valid <= 1'b1;
    in_if.data  <= {drain, pix};
    do @(posedge clk_i); while (!in_if.ready);
    if (sobel_step(drain, pix, res)) mag_q.push_back(typed ? tres : res);
    n_items++;
    idle_gap();
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (mag_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == RegFrameWidth) fw_q = val[10:0];
    else fh_q = val;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_pix();
    logic [23:0] p;
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 3))
        0: p[i*8 +: 8] = 8'h00;
        1: p[i*8 +: 8] = 8'hff;
        default: p[i*8 +: 8] = $urandom_range(0, 255);
      endcase
    return p;
  endfunction

  // a whole frame: noise drains ahead, pixels with early drains, flush with strays
  task automatic run_frame(logic [12:0] fw, logic [12:0] fh, bit noisy);
    int unsigned n;
    wait_idle();
    write_reg(RegFrameWidth, fw);
    write_reg(RegFrameHeight, fh);
    frame_done = 1'b0;
    if (noisy && $urandom_range(0, 2) == 0) send_beat(1'b1, rand_pix(), 0, '0);
    n = width_eff() * height_eff();
    for (int i = 0; i < n; i++)
      send_beat(noisy && $urandom_range(0, 19) == 0, rand_pix(), 0, '0);
    while (!frame_done)
      send_beat(!(noisy && $urandom_range(0, 9) == 0), rand_pix(), 0, '0);
  endtask

  stim_row_t dir_tab [] = '{
    '{RowCfg, 13'd1, RegFrameWidth,  24'h0, 0, '0},
    '{RowCfg, 13'd1, RegFrameHeight, 24'h0, 0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0},     // ignored at frame start
    '{RowPix, 13'd0, 1'b0, 24'hff0080, 0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      1, {8'd0, 8'd0, 8'd0, 1'b1}},
    '{RowCfg, 13'd3, RegFrameWidth,  24'h0, 0, '0},
    '{RowCfg, 13'd2, RegFrameHeight, 24'h0, 0, '0},
    '{RowPix, 13'd0, 1'b0, 24'hffffff, 0, '0},
    '{RowPix, 13'd0, 1'b0, 24'h000000, 0, '0},
    '{RowPix, 13'd0, 1'b0, 24'hffffff, 0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0},     // early drain, zero pixel
    '{RowPix, 13'd0, 1'b0, 24'h00ff00, 0, '0},
    '{RowPix, 13'd0, 1'b0, 24'hff00ff, 0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0},
    '{RowPix, 13'd0, 1'b0, 24'h123456, 0, '0},     // stray pixel in the flush
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0},
    '{RowDrn, 13'd0, 1'b0, 24'h0,      0, '0}
  };

  // result check
  always @(posedge clk_i) begin
    logic [24:0] e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (mag_q.size() == 0) begin
        $error("unexpected beat %h", out_if.data);
        errs++;
      end else begin
        e = mag_q.pop_front();
        if (e[24:17] != out_if.data[24:17]) begin
          $error("out_red exp %0d got %0d", e[24:17], out_if.data[24:17]); errs++;
        end
        if (e[16:9] != out_if.data[16:9]) begin
          $error("out_green exp %0d got %0d", e[16:9], out_if.data[16:9]); errs++;
        end
        if (e[8:1] != out_if.data[8:1]) begin
          $error("out_blue exp %0d got %0d", e[8:1], out_if.data[8:1]); errs++;
        end
        if (e[0] != out_if.data[0]) begin
          $error("frame_end exp %0d got %0d", e[0], out_if.data[0]); errs++;
        end
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready) || !rst_ni)
      quiet_cnt <= 0;
    else if (quiet_cnt >= StallLimit) begin
      $display("tb_sobel_edge_rgb: done, errors");
      $finish;
    end else
      quiet_cnt <= quiet_cnt + 1;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    errs = 0; n_items = 0; quiet_cnt = 0; quiet = 0; hold_req = 0;
    fw_q = 11'd1024; fh_q = 13'd768;
    for (int i = 0; i < 2*LineLen; i++) lstore[i] = '0;
    clear_frame();
    #1 rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else
        send_beat(dir_tab[i].kind == RowDrn, dir_tab[i].pix,
                  dir_tab[i].typed, dir_tab[i].res);
    end

    // register extremes: zero sizes clamp to one, single rows and columns
    run_frame(13'd0, 13'd0, 1);
    run_frame(13'd1, 13'd1, 1);
    run_frame(13'd7, 13'd1, 0);
    run_frame(13'd1, 13'd7, 0);
    run_frame(13'd2, 13'd3, 1);

    n_items = 0;
    while (n_items < RandItems) begin
      if (n_items > 150 && n_items < 250) hold_req = 1'b1;
      run_frame($urandom_range(1, 7), $urandom_range(1, 6), $urandom_range(0, 3) != 0);
    end
    quiet = 1'b1;
    run_frame(13'd5, 13'd4, 0);
    run_frame(13'd3, 13'd3, 1);

    in_if.valid <= 1'b0;
    while (mag_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0)
      $display("tb_sobel_edge_rgb: done, clean");
    else
      $display("tb_sobel_edge_rgb: done, errors");
    $finish;
  end
endmodule
